// File: rtl/core/ttst_pkg.sv
// package: command and status codes, sequencer states
package ttst_pkg;
    typedef enum logic [1:0] {
        CMD_TICK = 2'd0,
        CMD_ADD  = 2'd1,
        CMD_REM  = 2'd2,
        CMD_RUN  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_DUP      = 3'd1,
        ST_FULL     = 3'd2,
        ST_NOFUNC   = 3'd3,
        ST_NOTFOUND = 3'd4,
        ST_NOREADY  = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_DONE
    } t_state;
endpackage

// File: rtl/core/tick_task_scheduler_table.sv
// top level: cooperative tick task scheduler table with a walking sequencer
// walk: the sequencer steps through the listed positions in order, then an end state; a drop
//   stops the walk and closes the gap, and a run also stops at its first ready entry
// throughput: one command at a time; ready stays low until the result beat is taken
// the walk is set by a single shared slot port (one table entry read or written per cycle)
// reset clears the used bits and the list length; table payload is not reset
module tick_task_scheduler_table
    import ttst_pkg::*;
#(
    parameter int SLOTS     = 16,
    parameter int TIME_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_command,
    input  logic [7:0]  i_task_id,
    input  logic        i_function_present,
    input  logic [15:0] i_initial_delay,
    input  logic [15:0] i_period,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic        o_dispatched_valid,
    output logic [7:0]  o_dispatched_task_id,
    output logic        o_dispatched_one_shot
);
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int LW = $clog2(SLOTS + 1);

    // per-slot storage; the order list holds slot numbers
    logic [SLOTS-1:0]   r_used;
    logic [7:0]         r_task   [SLOTS];
    logic [TIME_BITS-1:0] r_rem  [SLOTS];
    logic [TIME_BITS-1:0] r_rel  [SLOTS];
    logic [SLOTS-1:0]   r_rdy;
    logic [SW-1:0]      r_order  [SLOTS];
    logic [LW-1:0]      r_len;

    // latched command beat
    t_cmd               r_cmd;
    logic [7:0]         r_id;
    logic               r_fn;
    logic [TIME_BITS-1:0] r_delay;
    logic [TIME_BITS-1:0] r_per;

    t_state             r_state, n_state;
    logic [LW-1:0]      r_pos;      // walk position in the order
    logic [SW-1:0]      r_free;     // lowest unused slot
    logic               r_free_ok;
    logic               r_removed;  // a remove found its entry

    // result beat register
    logic               r_ovalid;
    t_status            r_status;
    logic               r_dv;
    logic [7:0]         r_did;
    logic               r_dos;

    // current slot under the walker
    logic [SW-1:0]      w_slot;
    logic               w_in_list;
    logic [TIME_BITS-1:0] w_dec;
    logic               w_free_ok;
    logic [SW-1:0]      w_free;
    logic               w_drop;     // entry under the walker leaves the list

    assign w_in_list = (r_pos < r_len);
    assign w_slot    = r_order[r_pos[SW-1:0]];
    assign w_dec     = (r_rem[w_slot] != '0) ? r_rem[w_slot] - 1'b1 : r_rem[w_slot];
    assign w_drop    = (r_cmd == CMD_REM && r_task[w_slot] == r_id) ||
                       (r_cmd == CMD_RUN && r_rdy[w_slot] && r_rel[w_slot] == '0);

    // priority pick of a free slot, only used on add
    always_comb begin
        w_free_ok = 1'b0;
        w_free    = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                w_free_ok = 1'b1;
                w_free    = SW'(i);
            end
        end
    end

    assign o_ready = (r_state == S_IDLE) && !r_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_valid && o_ready) n_state = S_SCAN;
            S_SCAN: begin
                if (!w_in_list) n_state = S_DONE;
                else if (w_drop) n_state = S_SHIFT;
                else if (r_cmd == CMD_RUN && r_rdy[w_slot]) n_state = S_DONE;
            end
            S_SHIFT: if ({1'b0, r_pos} + 1'b1 >= {1'b0, r_len}) n_state = S_DONE;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used   <= '0;
            r_len    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_valid && o_ready) begin
                    r_cmd     <= t_cmd'(i_command);
                    r_id      <= i_task_id;
                    r_fn      <= i_function_present;
                    r_delay   <= TIME_BITS'(i_initial_delay);
                    r_per     <= TIME_BITS'(i_period);
                    r_pos     <= '0;
                    r_free    <= w_free;
                    r_free_ok <= w_free_ok;
                    r_status  <= ST_OK;
                    r_dv      <= 1'b0;
                    r_did     <= '0;
                    r_dos     <= 1'b0;
                end
                S_SCAN: if (w_in_list) begin
                    // a drop holds the position for the gap closing pass
                    if (!w_drop) r_pos <= r_pos + 1'b1;
                    case (r_cmd)
                        CMD_TICK: begin
                            if (w_dec == '0) begin
                                r_rdy[w_slot] <= 1'b1;
                                r_rem[w_slot] <= r_rel[w_slot];
                            end else begin
                                r_rem[w_slot] <= w_dec;
                            end
                        end
                        CMD_ADD: if (r_task[w_slot] == r_id) r_status <= ST_DUP;
                        CMD_REM: if (r_task[w_slot] == r_id) begin
                            r_used[w_slot] <= 1'b0;
                            r_len <= r_len - 1'b1;
                        end
                        CMD_RUN: if (r_rdy[w_slot]) begin
                            r_rdy[w_slot] <= 1'b0;
                            r_dv  <= 1'b1;
                            r_did <= r_task[w_slot];
                            if (r_rel[w_slot] == '0) begin
                                r_dos <= 1'b1;
                                r_used[w_slot] <= 1'b0;
                                r_len <= r_len - 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
                S_SHIFT: begin
                    // r_len already reduced: move one order entry down
                    if (r_pos < r_len)
                        r_order[r_pos[SW-1:0]] <= r_order[SW'(r_pos + 1'b1)];
                    r_pos <= r_pos + 1'b1;
                end
                S_DONE: begin
                    r_ovalid <= 1'b1;
                    if (r_cmd == CMD_ADD) begin
                        if (!r_fn) r_status <= ST_NOFUNC;
                        else if (r_status == ST_DUP) r_status <= ST_DUP;
                        else if (r_len >= LW'(SLOTS) || !r_free_ok) r_status <= ST_FULL;
                        else begin
                            r_used[r_free]  <= 1'b1;
                            r_task[r_free]  <= r_id;
                            r_rem[r_free]   <= r_delay;
                            r_rel[r_free]   <= r_per;
                            r_rdy[r_free]   <= (r_delay == '0);
                            r_order[r_len[SW-1:0]] <= r_free;
                            r_len <= r_len + 1'b1;
                        end
                    end else if (r_cmd == CMD_REM) begin
                        if (!r_removed) r_status <= ST_NOTFOUND;
                    end else if (r_cmd == CMD_RUN && !r_dv) begin
                        r_status <= ST_NOREADY;
                    end
                end
                default: ;
            endcase
        end
    end

    // remember that a remove found its entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_removed <= 1'b0;
        else if (r_state == S_IDLE) r_removed <= 1'b0;
        else if (r_state == S_SCAN && w_in_list && r_cmd == CMD_REM && r_task[w_slot] == r_id)
            r_removed <= 1'b1;
    end

    assign o_valid               = r_ovalid;
    assign o_status              = r_status;
    assign o_dispatched_valid    = r_dv;
    assign o_dispatched_task_id  = r_did;
    assign o_dispatched_one_shot = r_dos;

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LW'(SLOTS)) else $error("list length over capacity");
    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_ready) else $error("ready while walking");
    a_oneshot_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_dispatched_one_shot) |-> o_dispatched_valid)
        else $error("one-shot without dispatch");
endmodule
